// File: hdl/nsg_pkg.sv
`timescale 1ns / 1ps
package nsg_pkg;

  localparam int DEF_MAX_SAMPLES = 256;
  localparam int DEF_MAX_CORNERS = 1024;

  localparam int Q_W    = 16;
  localparam int DIST_W = 18;
  localparam int ENT_W  = 4 * Q_W;
  localparam int SUM_W  = 28;
  localparam int CFG_W  = 18;
  localparam int IDX_W  = 3;
  localparam int CNT_OUT_W = 9;

  localparam logic [SUM_W-1:0] SUM_MAX  = '1;
  localparam logic [Q_W-1:0]   FULL_Q16 = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_INTERVAL = 3'd0,
    REG_DIST_THRESH  = 3'd1,
    REG_MAX_SPEED    = 3'd2,
    REG_ENOUGH       = 3'd3,
    REG_RANGE_X      = 3'd4,
    REG_RANGE_Y      = 3'd5,
    REG_RANGE_SIZE   = 3'd6,
    REG_RANGE_SKEW   = 3'd7
  } cfg_reg_t;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_CORNER = 3'd1;
  localparam logic [2:0] MODE_CHECK  = 3'd2;
  localparam logic [2:0] MODE_ADD    = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [DIST_W-1:0] RST_DIST_THRESH = 18'd13107;
  localparam logic [8:0]        RST_ENOUGH      = 9'd40;
  localparam logic [Q_W-1:0]    RST_RANGE_XY    = 16'd45875;
  localparam logic [Q_W-1:0]    RST_RANGE_SIZE  = 16'd26214;
  localparam logic [Q_W-1:0]    RST_RANGE_SKEW  = 16'd32768;

  // divider handshake
  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] span;
    logic [Q_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: hdl/novel_sample_gate_with_coverage_top.sv
`timescale 1ns / 1ps
// Novelty gate for calibration poses. One request in, one result out. A tick runs up to
// four coverage divides on one shared 16-step divider. A corner pair adds the
// 17-step integer square root. A check adds the table scan: one sample table read per
// stored sample (up to MAX_SAMPLES) through a four-cell distance chain, then the drain
// and the speed test. A new request is taken while the last result still waits on
// out_stall.
module novel_sample_gate_with_coverage_top #(
  parameter int MAX_SAMPLES = nsg_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_CORNERS = nsg_pkg::DEF_MAX_CORNERS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    mode,
  input  logic [nsg_pkg::Q_W-1:0]       param_x,
  input  logic [nsg_pkg::Q_W-1:0]       param_y,
  input  logic [nsg_pkg::Q_W-1:0]       param_size,
  input  logic [nsg_pkg::Q_W-1:0]       param_skew,
  input  logic [nsg_pkg::Q_W-1:0]       cur_x,
  input  logic [nsg_pkg::Q_W-1:0]       cur_y,
  input  logic [nsg_pkg::Q_W-1:0]       prev_x,
  input  logic [nsg_pkg::Q_W-1:0]       prev_y,
  input  logic                          sets_differ,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          accept,
  output logic [nsg_pkg::CNT_OUT_W-1:0] pose_total,
  output logic [nsg_pkg::Q_W-1:0]       cover_x,
  output logic [nsg_pkg::Q_W-1:0]       cover_y,
  output logic [nsg_pkg::Q_W-1:0]       cover_size,
  output logic [nsg_pkg::Q_W-1:0]       cover_skew,
  output logic                          collect_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nsg_pkg::IDX_W-1:0]     cfg_index,
  input  logic [nsg_pkg::CFG_W-1:0]     cfg_data
);
  import nsg_pkg::*;

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CCW = $clog2(MAX_CORNERS + 1);
  localparam int GW  = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
  localparam int SQ_W = 34;
  localparam int PW  = Q_W + CCW;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SQINIT, S_SQRT, S_ACC, S_SCAN, S_DRAIN, S_SPD, S_DECIDE,
    S_COV, S_DIVW, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [Q_W-1:0]    min_interval;
  logic [DIST_W-1:0] dist_thresh;
  logic [Q_W-1:0]    max_speed;
  logic [8:0]        enough;
  logic [Q_W-1:0]    range_x, range_y, range_size, range_skew;

  // block state
  logic [CW-1:0]     count;
  logic [Q_W-1:0]    low_x, low_y, high_x, high_y, high_size, high_skew;
  logic [Q_W-1:0]    elapsed;
  logic [SUM_W-1:0]  motion_sum;
  logic [CCW-1:0]    corner_count;

  // working registers
  logic [Q_W-1:0]    qv [4];
  logic              q_differ;
  logic [Q_W-1:0]    dx, dy;
  logic [2*Q_W-1:0]  px, py;
  logic [SQ_W-1:0]   sq_v, sq_r, sq_bit;
  logic [AW-1:0]     scan_addr;
  logic              rd_valid;
  logic [2:0]        drain;
  logic [DIST_W-1:0] best;
  logic [PW-1:0]     spd_prod;
  logic              acc_r;
  logic [Q_W-1:0]    cov [4];
  logic              full_r;
  logic [1:0]        axis;

  logic              in_fire;
  logic              out_free;
  logic              timer_ready;
  logic              ram_we;
  logic [ENT_W-1:0]  ram_rdata;
  logic [Q_W-1:0]    cx_dx, cy_dy;
  logic [SQ_W-1:0]   sq_try;
  logic [SUM_W:0]    sum_ext;
  logic [Q_W-1:0]    span, rng, rng_eff;
  logic              need_div;
  logic              moving;
  logic [GW-1:0]     count_g, enough_g;
  div_req_t          dreq;
  div_rsp_t          drsp;

  logic              vld_c [5];
  logic [DIST_W-1:0] sum_c [5];
  logic [ENT_W-1:0]  ent_c [5];

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign timer_ready = (min_interval == '0) || (elapsed >= min_interval);
  assign ram_we = in_fire && (mode == MODE_ADD) && (count < CW'(MAX_SAMPLES));

  assign cx_dx  = (cur_x > prev_x) ? cur_x - prev_x : prev_x - cur_x;
  assign cy_dy  = (cur_y > prev_y) ? cur_y - prev_y : prev_y - cur_y;
  assign sq_try = sq_r + sq_bit;
  assign sum_ext = {1'b0, motion_sum} + (SUM_W+1)'(sq_r);

  always_comb begin
    unique case (axis)
      2'd0: begin span = high_x - low_x; rng = range_x;    end
      2'd1: begin span = high_y - low_y; rng = range_y;    end
      2'd2: begin span = high_size;      rng = range_size; end
      default: begin span = high_skew;   rng = range_skew; end
    endcase
  end
  assign rng_eff  = (rng == '0) ? Q_W'(1) : rng;
  assign need_div = (count != '0) && (span < rng_eff);

  assign dreq.start = (state == S_COV) && need_div;
  assign dreq.span  = span;
  assign dreq.den   = rng_eff;

  assign moving = (corner_count == '0) || q_differ
                  || ((PW+SUM_W)'(motion_sum) > (PW+SUM_W)'(spd_prod));

  assign count_g  = GW'(count);
  assign enough_g = GW'(enough);

  nsg_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SAMPLES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata ({param_skew, param_size, param_y, param_x}),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  assign vld_c[0] = rd_valid;
  assign sum_c[0] = '0;
  assign ent_c[0] = ram_rdata;

  for (genvar g = 0; g < 4; g++) begin : g_cell
    nsg_cell #(.AXIS(g)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (vld_c[g]),
      .sum_in    (sum_c[g]),
      .entry_in  (ent_c[g]),
      .query     (qv[g]),
      .valid_out (vld_c[g+1]),
      .sum_out   (sum_c[g+1]),
      .entry_out (ent_c[g+1])
    );
  end

  nsg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= '0;
      dist_thresh  <= RST_DIST_THRESH;
      max_speed    <= '0;
      enough       <= RST_ENOUGH;
      range_x      <= RST_RANGE_XY;
      range_y      <= RST_RANGE_XY;
      range_size   <= RST_RANGE_SIZE;
      range_skew   <= RST_RANGE_SKEW;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MIN_INTERVAL: min_interval <= cfg_data[Q_W-1:0];
        REG_DIST_THRESH:  dist_thresh  <= cfg_data;
        REG_MAX_SPEED:    max_speed    <= cfg_data[Q_W-1:0];
        REG_ENOUGH:       enough       <= cfg_data[8:0];
        REG_RANGE_X:      range_x      <= cfg_data[Q_W-1:0];
        REG_RANGE_Y:      range_y      <= cfg_data[Q_W-1:0];
        REG_RANGE_SIZE:   range_size   <= cfg_data[Q_W-1:0];
        default:          range_skew   <= cfg_data[Q_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= (state == S_SCAN);
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      low_x        <= '0;
      low_y        <= '0;
      high_x       <= '0;
      high_y       <= '0;
      high_size    <= '0;
      high_skew    <= '0;
      elapsed      <= '1;
      motion_sum   <= '0;
      corner_count <= '0;
      out_valid    <= 1'b0;
      acc_r        <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            qv[0]    <= param_x;
            qv[1]    <= param_y;
            qv[2]    <= param_size;
            qv[3]    <= param_skew;
            q_differ <= sets_differ;
            dx       <= cx_dx;
            dy       <= cy_dy;
            axis     <= '0;
            full_r   <= 1'b1;
            unique case (mode)
              MODE_TICK: begin
                acc_r <= 1'b0;
                state <= S_COV;
                if (elapsed != '1) begin
                  elapsed <= elapsed + Q_W'(1);
                end
              end
              MODE_CORNER: begin
                acc_r <= 1'b0;
                if (corner_count < CCW'(MAX_CORNERS)) begin
                  state <= S_MUL;
                end else begin
                  state <= S_COV;
                end
              end
              MODE_CHECK: begin
                if (!timer_ready) begin
                  acc_r        <= 1'b0;
                  motion_sum   <= '0;
                  corner_count <= '0;
                  state        <= S_COV;
                end else if (count == '0) begin
                  acc_r        <= 1'b1;
                  motion_sum   <= '0;
                  corner_count <= '0;
                  state        <= S_COV;
                end else begin
                  acc_r     <= 1'b0;
                  scan_addr <= '0;
                  best      <= '1;
                  state     <= S_SCAN;
                end
              end
              MODE_ADD: begin
                acc_r <= 1'b0;
                state <= S_COV;
                if (count < CW'(MAX_SAMPLES)) begin
                  if (count == '0) begin
                    low_x     <= param_x;
                    high_x    <= param_x;
                    low_y     <= param_y;
                    high_y    <= param_y;
                    high_size <= param_size;
                    high_skew <= param_skew;
                  end else begin
                    if (param_x < low_x) low_x <= param_x;
                    if (param_x > high_x) high_x <= param_x;
                    if (param_y < low_y) low_y <= param_y;
                    if (param_y > high_y) high_y <= param_y;
                    if (param_size > high_size) high_size <= param_size;
                    if (param_skew > high_skew) high_skew <= param_skew;
                  end
                  count <= count + CW'(1);
                end
                elapsed <= '0;
              end
              MODE_CLEAR: begin
                acc_r     <= 1'b0;
                state     <= S_COV;
                count     <= '0;
                low_x     <= '0;
                low_y     <= '0;
                high_x    <= '0;
                high_y    <= '0;
                high_size <= '0;
                high_skew <= '0;
                elapsed   <= '1;
              end
              default: begin
                acc_r <= 1'b0;
                state <= S_COV;
              end
            endcase
          end
        end
        S_MUL: begin
          px    <= dx * dx;
          py    <= dy * dy;
          state <= S_SQINIT;
        end
        S_SQINIT: begin
          sq_v   <= SQ_W'(px) + SQ_W'(py);
          sq_r   <= '0;
          sq_bit <= SQ_W'(1) << 32;
          state  <= S_SQRT;
        end
        S_SQRT: begin
          // one result bit per cycle
          if (sq_v >= sq_try) begin
            sq_v <= sq_v - sq_try;
            sq_r <= (sq_r >> 1) + sq_bit;
          end else begin
            sq_r <= sq_r >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit[0]) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          motion_sum   <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
          corner_count <= corner_count + CCW'(1);
          state        <= S_COV;
        end
        S_SCAN: begin
          scan_addr <= scan_addr + AW'(1);
          if (CW'(scan_addr) + CW'(1) == count) begin
            drain <= 3'd5;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain <= drain - 3'd1;
          if (drain == 3'd0) begin
            state <= S_SPD;
          end
        end
        S_SPD: begin
          spd_prod <= PW'(max_speed) * PW'(corner_count);
          state    <= S_DECIDE;
        end
        S_DECIDE: begin
          acc_r        <= (best > dist_thresh) && ((max_speed == '0) || !moving);
          motion_sum   <= '0;
          corner_count <= '0;
          state        <= S_COV;
        end
        S_COV: begin
          if (need_div) begin
            full_r <= 1'b0;
            state  <= S_DIVW;
          end else begin
            cov[axis] <= (count == '0) ? '0 : FULL_Q16;
            axis      <= axis + 2'd1;
            if (axis == 2'd3) begin
              state <= S_OUT;
            end
          end
        end
        S_DIVW: begin
          if (drsp.done) begin
            cov[axis] <= drsp.quo;
            axis      <= axis + 2'd1;
            state     <= (axis == 2'd3) ? S_OUT : S_COV;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            accept       <= acc_r;
            pose_total   <= CNT_OUT_W'(count);
            cover_x      <= cov[0];
            cover_y      <= cov[1];
            cover_size   <= cov[2];
            cover_skew   <= cov[3];
            collect_done <= (count != '0) && ((count_g >= enough_g) || full_r);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (vld_c[4] && (sum_c[4] < best)) begin
      best <= sum_c[4];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_SAMPLES))
    else $error("sample count beyond table depth");

  a_corner_bound: assert property (@(posedge clk) disable iff (rst)
    corner_count <= CCW'(MAX_CORNERS))
    else $error("corner count beyond limit");

  a_out_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result shown outside output state");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    drsp.busy |-> state == S_DIVW)
    else $error("divider running outside coverage wait");
endmodule

// File: hdl/nsg_ram.sv
`timescale 1ns / 1ps
module nsg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/nsg_cell.sv
`timescale 1ns / 1ps
module nsg_cell #(
  parameter int AXIS = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid_in,
  input  logic [nsg_pkg::DIST_W-1:0]  sum_in,
  input  logic [nsg_pkg::ENT_W-1:0]   entry_in,
  input  logic [nsg_pkg::Q_W-1:0]     query,
  output logic                        valid_out,
  output logic [nsg_pkg::DIST_W-1:0]  sum_out,
  output logic [nsg_pkg::ENT_W-1:0]   entry_out
);
  import nsg_pkg::*;

  logic [Q_W-1:0] stored;
  logic [Q_W-1:0] diff;

  assign stored = entry_in[AXIS*Q_W +: Q_W];
  assign diff   = (query > stored) ? query - stored : stored - query;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    sum_out   <= sum_in + DIST_W'(diff);
    entry_out <= entry_in;
  end
endmodule

// File: hdl/nsg_div.sv
`timescale 1ns / 1ps
module nsg_div (
  input  logic              clk,
  input  logic              rst,
  input  nsg_pkg::div_req_t req,
  output nsg_pkg::div_rsp_t rsp
);
  import nsg_pkg::*;

  logic [Q_W-1:0] rem;
  logic [Q_W-1:0] den;
  logic [Q_W-1:0] quo;
  logic [4:0]     cnt;
  logic           busy;
  logic           done;
  logic [Q_W:0]   rem2;
  logic           ge;

  // restoring division of span * 2^16 by den, span < den
  assign rem2 = {rem, 1'b0};
  assign ge   = rem2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
    if (req.start) begin
      rem <= req.span;
      den <= req.den;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? Q_W'(rem2 - {1'b0, den}) : rem2[Q_W-1:0];
      quo <= {quo[Q_W-2:0], ge};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = quo;
endmodule

// File: verif/tb_novel_sample_gate_with_coverage_top.sv
`timescale 1ns / 1ps
module tb_novel_sample_gate_with_coverage_top;
  import nsg_pkg::*;

  localparam int TABLE_DEPTH = DEF_MAX_SAMPLES;
  localparam int CORNER_CAP  = DEF_MAX_CORNERS;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic        accept;
    logic [8:0]  count;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] cs;
    logic [15:0] ck;
    logic        good;
  } gate_res_t;

  typedef struct packed {
    logic [2:0]  m;
    logic [15:0] px, py, ps, pk;
    logic [15:0] ux, uy, vx, vy;
    logic        sd;
    logic        typed;
    gate_res_t   res;
  } pose_req_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_stall;
  logic [2:0] mode = '0;
  logic [15:0] param_x = '0, param_y = '0, param_size = '0, param_skew = '0;
  logic [15:0] cur_x = '0, cur_y = '0, prev_x = '0, prev_y = '0;
  logic sets_differ = 0;
  logic out_valid, out_stall = 0;
  logic accept, collect_done;
  logic [8:0] pose_total;
  logic [15:0] cover_x, cover_y, cover_size, cover_skew;
  logic cfg_valid = 0, cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // typed expectation travels with the request
  logic      row_typed = 0;
  gate_res_t row_res = '0;

  logic idle_on = 1;
  logic hold_req = 0, hold_done = 0;
  int   hold_left = 0;
  int   cyc = 0, errors = 0, n_sent = 0, n_pass = 0, n_settings = 0, peak = 0;

  gate_res_t result_q[$];

  // predictor state
  logic [15:0] tbl[TABLE_DEPTH][4];
  int          tcount = 0;
  logic [15:0] lo_x = 0, lo_y = 0, hi_x = 0, hi_y = 0, hi_size = 0, hi_skew = 0;
  logic [15:0] elapsed = 16'hFFFF;
  logic [27:0] msum = 0;
  int          corners = 0;
  logic [15:0] c_interval = 0, c_speed = 0;
  logic [17:0] c_thresh = RST_DIST_THRESH;
  logic [8:0]  c_enough = RST_ENOUGH;
  logic [15:0] c_rx = RST_RANGE_XY, c_ry = RST_RANGE_XY;
  logic [15:0] c_rs = RST_RANGE_SIZE, c_rk = RST_RANGE_SKEW;

  novel_sample_gate_with_coverage_top DUT (.*);

  always #6 clk = ~clk;

  function automatic logic [16:0] root_floor(input logic [33:0] v);
    logic [16:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 16; b >= 0; b--) begin
      c = 34'(r | (17'd1 << b));
      if (c * c <= v) r = c[16:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] coverage(input logic [15:0] span, input logic [15:0] rng);
    logic [31:0] rr;
    rr = (rng == 0) ? 32'd1 : {16'd0, rng};
    if ({16'd0, span} >= rr) return 16'hFFFF;
    return 16'(({span, 16'd0}) / rr);
  endfunction

  function automatic logic [16:0] adiff(input logic [15:0] a, input logic [15:0] b);
    return (a > b) ? 17'(a - b) : 17'(b - a);
  endfunction

  task automatic gate_predict(input pose_req_t q, output gate_res_t r);
    logic [16:0] dx, dy;
    logic [28:0] s;
    logic [18:0] best, d;
    logic ok;
    r = '0;
    case (q.m)
      MODE_TICK: if (elapsed != 16'hFFFF) elapsed++;
      MODE_CORNER: if (corners < CORNER_CAP) begin
        dx = adiff(q.ux, q.vx);
        dy = adiff(q.uy, q.vy);
        s = {1'b0, msum} + root_floor(34'(dx) * dx + 34'(dy) * dy);
        msum = (s > SUM_MAX) ? SUM_MAX : s[27:0];
        corners++;
      end
      MODE_CHECK: begin
        ok = 1;
        if (c_interval != 0 && elapsed < c_interval) ok = 0;
        else if (tcount != 0) begin
          best = '1;
          for (int i = 0; i < tcount; i++) begin
            d = adiff(q.px, tbl[i][0]) + adiff(q.py, tbl[i][1])
              + adiff(q.ps, tbl[i][2]) + adiff(q.pk, tbl[i][3]);
            if (d < best) best = d;
          end
          if (best <= c_thresh) ok = 0;
          else if (c_speed != 0) begin
            if (corners == 0 || q.sd) ok = 0;
            else if (64'(msum) > 64'(c_speed) * corners) ok = 0;
          end
        end
        r.accept = ok;
        msum = 0;
        corners = 0;
      end
      MODE_ADD: begin
        if (tcount < TABLE_DEPTH) begin
          tbl[tcount] = '{q.px, q.py, q.ps, q.pk};
          if (tcount == 0) begin
            lo_x = q.px; hi_x = q.px; lo_y = q.py; hi_y = q.py;
            hi_size = q.ps; hi_skew = q.pk;
          end else begin
            if (q.px < lo_x) lo_x = q.px;
            if (q.px > hi_x) hi_x = q.px;
            if (q.py < lo_y) lo_y = q.py;
            if (q.py > hi_y) hi_y = q.py;
            if (q.ps > hi_size) hi_size = q.ps;
            if (q.pk > hi_skew) hi_skew = q.pk;
          end
          tcount++;
        end
        elapsed = 0;
      end
      MODE_CLEAR: begin
        tcount = 0;
        lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0; hi_size = 0; hi_skew = 0;
        elapsed = 16'hFFFF;
      end
      default: ;
    endcase
    r.count = 9'(tcount);
    if (tcount != 0) begin
      r.cx = coverage(hi_x - lo_x, c_rx);
      r.cy = coverage(hi_y - lo_y, c_ry);
      r.cs = coverage(hi_size, c_rs);
      r.ck = coverage(hi_skew, c_rk);
      r.good = (tcount >= c_enough) ||
               (&{r.cx == 16'hFFFF, r.cy == 16'hFFFF, r.cs == 16'hFFFF, r.ck == 16'hFFFF});
    end
    if (tcount > peak) peak = tcount;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cyc, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("tb_novel_sample_gate_with_coverage_top: errors");
      $finish;
    end
  end

  // accepted request -> expected result
  always @(posedge clk) begin
    pose_req_t q;
    gate_res_t r;
    if (!rst && in_valid && !in_stall) begin
      q = '{mode, param_x, param_y, param_size, param_skew, cur_x, cur_y, prev_x, prev_y,
            sets_differ, row_typed, row_res};
      gate_predict(q, r);
      if (q.m == MODE_CHECK && r.accept) n_pass++;
      result_q.insert(result_q.size(), row_typed ? row_res : r);
    end
  end

  always @(posedge clk) begin
    gate_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) report("unexpected result, count", pose_total, 0);
      else begin
        e = result_q.pop_front();
        if (accept !== e.accept) report("accept", accept, e.accept);
        if (pose_total !== e.count) report("pose_total", pose_total, e.count);
        if (cover_x !== e.cx) report("cover_x", cover_x, e.cx);
        if (cover_y !== e.cy) report("cover_y", cover_y, e.cy);
        if (cover_size !== e.cs) report("cover_size", cover_size, e.cs);
        if (cover_skew !== e.ck) report("cover_skew", cover_skew, e.ck);
        if (collect_done !== e.good) report("collect_done", collect_done, e.good);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_INTERVAL: c_interval <= cfg_data[15:0];
        REG_DIST_THRESH:  c_thresh   <= cfg_data[17:0];
        REG_MAX_SPEED:    c_speed    <= cfg_data[15:0];
        REG_ENOUGH:       c_enough   <= cfg_data[8:0];
        REG_RANGE_X:      c_rx       <= cfg_data[15:0];
        REG_RANGE_Y:      c_ry       <= cfg_data[15:0];
        REG_RANGE_SIZE:   c_rs       <= cfg_data[15:0];
        REG_RANGE_SKEW:   c_rk       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // result side back-pressure, with one long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1;
      hold_left <= 600;
      hold_done <= 1;
    end else begin
      out_stall <= idle_on ? ($urandom_range(99) < 25) : 1'b0;
    end
  end

  task automatic push_req(input pose_req_t q);
    while (idle_on && $urandom_range(99) < 25) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    mode <= q.m;
    param_x <= q.px; param_y <= q.py; param_size <= q.ps; param_skew <= q.pk;
    cur_x <= q.ux; cur_y <= q.uy; prev_x <= q.vx; prev_y <= q.vy;
    sets_differ <= q.sd;
    row_typed <= q.typed;
    row_res <= q.res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (q.m <= MODE_CLEAR) n_sent++;
  endtask

  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_all(input logic [15:0] iv, input logic [17:0] th, input logic [15:0] sp,
                           input logic [8:0] en, input logic [15:0] rx, input logic [15:0] ry,
                           input logic [15:0] rs, input logic [15:0] rk);
    settle();
    write_reg(REG_MIN_INTERVAL, 18'(iv));
    write_reg(REG_DIST_THRESH, th);
    write_reg(REG_MAX_SPEED, 18'(sp));
    write_reg(REG_ENOUGH, 18'(en));
    write_reg(REG_RANGE_X, 18'(rx));
    write_reg(REG_RANGE_Y, 18'(ry));
    write_reg(REG_RANGE_SIZE, 18'(rs));
    write_reg(REG_RANGE_SKEW, 18'(rk));
    cfg_valid <= 0;
    @(posedge clk);
    n_settings++;
  endtask

  function automatic pose_req_t make_req(input logic [2:0] m);
    pose_req_t q;
    q = '0;
    q.m = m;
    q.px = $urandom; q.py = $urandom; q.ps = $urandom; q.pk = $urandom;
    q.ux = $urandom; q.uy = $urandom;
    q.vx = q.ux + 16'($urandom_range(0, 400)) - 16'd200;
    q.vy = q.uy + 16'($urandom_range(0, 400)) - 16'd200;
    q.sd = ($urandom_range(99) < 10);
    return q;
  endfunction

  // a random-mode request or a clear now and then, else ticks, corner pairs, a check and mostly an add
  task automatic pose_sequence(input int tick_max);
    pose_req_t q, pose;
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      q = make_req(3'($urandom));
      q.vx = $urandom; q.vy = $urandom;
      q.sd = $urandom;
      push_req(q);
    end else if (r < 12) begin
      push_req(make_req(MODE_CLEAR));
    end else begin
      repeat ($urandom_range(0, tick_max)) push_req(make_req(MODE_TICK));
      repeat ($urandom_range(0, 6)) push_req(make_req(MODE_CORNER));
      pose = make_req(MODE_CHECK);
      push_req(pose);
      if ($urandom_range(99) < 70) begin
        pose.m = MODE_ADD;
        push_req(pose);
      end
    end
  endtask

  function automatic gate_res_t tr(input logic a, input logic [8:0] n, input logic [15:0] x,
                                    input logic [15:0] y, input logic [15:0] s,
                                    input logic [15:0] k, input logic g);
    return '{a, n, x, y, s, k, g};
  endfunction

  pose_req_t dir_rows[$];

  task automatic add_row(input pose_req_t row);
    dir_rows.insert(dir_rows.size(), row);
  endtask

  initial begin
    pose_req_t q;
    int target;
    for (int i = 0; i < TABLE_DEPTH; i++) tbl[i] = '{0, 0, 0, 0};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed rows; typed ones carry their expected result
    add_row('{MODE_TICK, 0,0,0,0, 0,0,0,0, 0, 1, tr(0,0,0,0,0,0,0)});
    add_row('{3'd5, '1,'1,'1,'1, '1,'1,'1,'1, 1, 1, tr(0,0,0,0,0,0,0)});
    add_row('{3'd6, 0,0,0,0, 0,0,0,0, 0, 1, tr(0,0,0,0,0,0,0)});
    add_row('{3'd7, '1,0,'1,0, '1,0,'1,0, 1, 1, tr(0,0,0,0,0,0,0)});
    add_row('{MODE_CHECK, 16'h1234,0,0,0, 0,0,0,0, 0, 1, tr(1,0,0,0,0,0,0)});
    add_row('{MODE_ADD, 0,0,'1,'1, 0,0,0,0, 0, 1,
              tr(0,1,0,0,16'hFFFF,16'hFFFF,0)});
    add_row('{MODE_ADD, '1,'1,0,0, 0,0,0,0, 0, 1,
              tr(0,2,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,1)});
    // same pose as stored: distance zero, rejected
    add_row('{MODE_CHECK, 0,0,'1,'1, 0,0,0,0, 0, 1,
              tr(0,2,16'hFFFF,16'hFFFF,16'hFFFF,16'hFFFF,1)});
    add_row('{MODE_CHECK, 16'h8000,16'h8000,16'h8000,16'h8000, 0,0,0,0, 0, 0, '0});
    add_row('{MODE_CORNER, 0,0,0,0, '1,'1,0,0, 0, 0, '0});
    add_row('{MODE_CORNER, 0,0,0,0, 0,0,'1,'1, 0, 0, '0});
    add_row('{MODE_CORNER, 0,0,0,0, 16'h5555,16'hAAAA,16'h5555,16'hAAAA, 0, 0, '0});
    add_row('{MODE_CHECK, 16'h4000,16'hC000,16'h2000,16'h9000, 0,0,0,0, 1, 0, '0});
    add_row('{MODE_CLEAR, 0,0,0,0, 0,0,0,0, 0, 1, tr(0,0,0,0,0,0,0)});
    add_row('{MODE_ADD, 16'h7FFF,16'h0001,16'h3000,16'h0100, 0,0,0,0, 0, 0, '0});
    add_row('{MODE_TICK, '1,'1,'1,'1, '1,'1,'1,'1, 1, 0, '0});
    add_row('{MODE_CHECK, 16'h7FFF,16'h0001,16'h3001,16'h0100, 0,0,0,0, 0, 0, '0});
    add_row('{MODE_ADD, 16'h0100,16'hFF00,16'hFFFF,16'h0000, 0,0,0,0, 0, 0, '0});
    foreach (dir_rows[i]) push_req(dir_rows[i]);

    // extremes: zero or one everywhere (a zero range acts as one), then the top, enough at table depth
    write_all(0, 0, 0, 0, 0, 1, 1, 0);
    target = n_sent + 250;
    while (n_sent < target) pose_sequence(3);
    write_all(16'hFFFF, 18'h3FFFF, 16'hFFFF, 9'd256, '1, '1, '1, '1);
    target = n_sent + 250;
    while (n_sent < target) pose_sequence(3);

    // fill the table past its depth, then full-length scans
    write_all(0, 0, 0, 9'd256, 16'd40000, 16'd40000, 16'd30000, 16'd30000);
    q = make_req(MODE_CLEAR);
    push_req(q);
    repeat (TABLE_DEPTH + 3) push_req(make_req(MODE_ADD));
    repeat (4) push_req(make_req(MODE_CHECK));
    push_req(make_req(MODE_CLEAR));

    // random settings; the first one also holds the result side off for a while
    for (int ph = 0; ph < 3; ph++) begin
      write_all(16'($urandom_range(0, 8)), 18'($urandom_range(0, 40000)),
                16'($urandom_range(1, 3000)), 9'($urandom_range(1, 60)),
                16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      if (ph == 0) hold_req = 1;
      idle_on = (ph != 2);
      target = n_sent + 290;
      while (n_sent < target) pose_sequence(10);
    end

    in_valid <= 0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    $display("covered %0d requests under %0d register settings", n_sent, n_settings + 1);
    $display("%0d checks passed, table held up to %0d poses", n_pass, peak);
    if (errors == 0) $display("tb_novel_sample_gate_with_coverage_top: clean");
    else $display("tb_novel_sample_gate_with_coverage_top: errors");
    $finish;
  end

endmodule

// File: filelist.f
hdl/nsg_pkg.sv
hdl/nsg_ram.sv
hdl/nsg_cell.sv
hdl/nsg_div.sv
hdl/novel_sample_gate_with_coverage_top.sv
verif/tb_novel_sample_gate_with_coverage_top.sv
